/* rtl/vna_pkg.sv */
// shared types, constants and state encodings of the vertex normal accumulator
package vna_pkg;

  localparam int VERTEX_DEPTH_DEF = 1024;
  localparam int IDX_W            = 10;
  localparam int CMD_W            = 2;
  localparam int DATA_W           = 32;
  localparam int UNIT_W           = 16;
  localparam int CR_W             = 65;
  localparam int MAG_W            = 64;
  localparam int FACE_W           = 18;
  localparam int Q_W              = 18;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRI     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_TRI,
    OP_READ,
    OP_READ_ZERO
  } op_kind_t;

  typedef struct packed {
    op_kind_t                 kind;
    logic [IDX_W-1:0]         idx_a;
    logic [IDX_W-1:0]         idx_b;
    logic [IDX_W-1:0]         idx_c;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] nrm_x;
    logic signed [DATA_W-1:0] nrm_y;
    logic signed [DATA_W-1:0] nrm_z;
  } op_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PR,
    B_PC,
    B_EDGE,
    B_HALF,
    B_MUL,
    B_NSTART,
    B_NWAIT,
    B_AR,
    B_AC,
    B_OUT
  } b_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIVINIT,
    N_DIV,
    N_DONE
  } n_state_t;

  typedef struct packed {
    logic start;
    logic frac16;
  } norm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_sts_t;

endpackage

/* rtl/vna_ifs.sv */
// valid/ready channel interfaces for commands and normal read-out
interface vna_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [vna_pkg::CMD_W-1:0]            command;
  logic [vna_pkg::IDX_W-1:0]            index_a;
  logic [vna_pkg::IDX_W-1:0]            index_b;
  logic [vna_pkg::IDX_W-1:0]            index_c;
  logic signed [vna_pkg::DATA_W-1:0]    pos_x_in;
  logic signed [vna_pkg::DATA_W-1:0]    pos_y_in;
  logic signed [vna_pkg::DATA_W-1:0]    pos_z_in;
  logic signed [vna_pkg::DATA_W-1:0]    start_nx;
  logic signed [vna_pkg::DATA_W-1:0]    start_ny;
  logic signed [vna_pkg::DATA_W-1:0]    start_nz;

  modport source (output valid, command, index_a, index_b, index_c, pos_x_in, pos_y_in,
                  pos_z_in, start_nx, start_ny, start_nz, input ready);
  modport sink (input valid, command, index_a, index_b, index_c, pos_x_in, pos_y_in,
                pos_z_in, start_nx, start_ny, start_nz, output ready);
endinterface

interface vna_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vna_pkg::UNIT_W-1:0]    unit_nx;
  logic signed [vna_pkg::UNIT_W-1:0]    unit_ny;
  logic signed [vna_pkg::UNIT_W-1:0]    unit_nz;

  modport source (output valid, unit_nx, unit_ny, unit_nz, input ready);
  modport sink (input valid, unit_nx, unit_ny, unit_nz, output ready);
endinterface

/* rtl/vna_front.sv */
// command intake: classification, range checks and two-entry queue
module vna_front #(
  parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  vna_in_if.sink        in_chan,
  output vna_pkg::op_t  head_o,
  output logic          head_valid_o,
  input  logic          pop_i
);

  vna_pkg::op_t       q_r [2];
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  logic [1:0]         wr_pos;
  logic               a_ok, b_ok, c_ok;
  logic               keep;
  logic               push;
  vna_pkg::op_kind_t  kind;
  vna_pkg::op_t       new_op;

  assign a_ok = ({22'd0, in_chan.index_a} < 32'(VERTEX_DEPTH));
  assign b_ok = ({22'd0, in_chan.index_b} < 32'(VERTEX_DEPTH));
  assign c_ok = ({22'd0, in_chan.index_c} < 32'(VERTEX_DEPTH));

  always_comb begin
    case (in_chan.command)
      vna_pkg::CMD_WRITE: begin
        keep = a_ok;
        kind = vna_pkg::OP_WRITE;
      end
      vna_pkg::CMD_TRI: begin
        keep = a_ok && b_ok && c_ok;
        kind = vna_pkg::OP_TRI;
      end
      vna_pkg::CMD_READ: begin
        keep = 1'b1;
        kind = a_ok ? vna_pkg::OP_READ : vna_pkg::OP_READ_ZERO;
      end
      default: begin
        keep = 1'b0;
        kind = vna_pkg::OP_WRITE;
      end
    endcase
  end

  always_comb begin
    new_op.kind  = kind;
    new_op.idx_a = in_chan.index_a;
    new_op.idx_b = in_chan.index_b;
    new_op.idx_c = in_chan.index_c;
    new_op.pos_x = in_chan.pos_x_in;
    new_op.pos_y = in_chan.pos_y_in;
    new_op.pos_z = in_chan.pos_z_in;
    new_op.nrm_x = in_chan.start_nx;
    new_op.nrm_y = in_chan.start_ny;
    new_op.nrm_z = in_chan.start_nz;
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready && keep;
  assign wr_pos        = cnt_r - {1'b0, pop_i};
  assign cnt_nxt       = cnt_r + {1'b0, push} - {1'b0, pop_i};
  assign head_o        = q_r[0];
  assign head_valid_o  = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_i) begin
      q_r[0] <= q_r[1];
    end
    if (push) begin
      q_r[wr_pos[0]] <= new_op;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop_i |-> cnt_r != 2'd0)
    else $error("pop from empty queue");

endmodule

/* rtl/vna_norm.sv */
// vector normaliser: range shift, sum of squares, bit-serial square root and division
module vna_norm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vna_pkg::norm_req_t                 req_i,
  input  logic signed [vna_pkg::CR_W-1:0]    vec_i [3],
  output vna_pkg::norm_sts_t                 sts_o,
  output logic signed [vna_pkg::FACE_W-1:0]  res_o [3]
);

  localparam logic [vna_pkg::MAG_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

  vna_pkg::n_state_t state_r, state_nxt;

  logic                              neg_r   [3];
  logic [vna_pkg::MAG_W-1:0]         mag_r   [3];
  logic [vna_pkg::MAG_W-1:0]         abs_w   [3];
  logic                              frac16_r;
  logic [4:0]                        cnt_r;
  logic [vna_pkg::MAG_W-1:0]         x_r, r_r, bit_r;
  logic [vna_pkg::MAG_W-1:0]         sq_t;
  logic [59:0]                       mul_r;
  logic [29:0]                       sq_sel;
  logic [vna_pkg::Q_W-1:0]           num_r   [3];
  logic [31:0]                       rem_r   [3];
  logic [vna_pkg::Q_W-1:0]           q_r     [3];
  logic [46:0]                       n_w     [3];
  logic [32:0]                       tmp_w   [3];
  logic [vna_pkg::Q_W-1:0]           qc_w    [3];
  logic [vna_pkg::Q_W-1:0]           lim_w;
  logic signed [vna_pkg::FACE_W-1:0] res_r   [3];
  logic                              done_r;
  logic [vna_pkg::MAG_W-1:0]         or_w;
  logic                              zero_in;
  logic                              shift_ok;
  logic [31:0]                       len_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_w[i] = vec_i[i][vna_pkg::CR_W-1] ? 64'(-vec_i[i]) : vec_i[i][vna_pkg::MAG_W-1:0];
    end
  end

  assign zero_in  = (abs_w[0] == '0) && (abs_w[1] == '0) && (abs_w[2] == '0);
  assign or_w     = mag_r[0] | mag_r[1] | mag_r[2];
  assign shift_ok = !(|or_w[63:30]) && or_w[29];
  assign sq_sel   = (cnt_r == 5'd0) ? mag_r[0][29:0] :
                    (cnt_r == 5'd1) ? mag_r[1][29:0] : mag_r[2][29:0];
  assign sq_t     = r_r + bit_r;
  assign len_w    = r_r[31:0];
  assign lim_w    = frac16_r ? 18'd65536 : 18'd16384;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_w[i]   = (frac16_r ? {1'b0, mag_r[i][29:0], 16'd0} : {3'd0, mag_r[i][29:0], 14'd0})
                 + {16'd0, len_w[31:1]};
      tmp_w[i] = {rem_r[i], num_r[i][vna_pkg::Q_W-1]};
      qc_w[i]  = (q_r[i] > lim_w) ? lim_w : q_r[i];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vna_pkg::N_IDLE:    if (req_i.start) begin
                            state_nxt = zero_in ? vna_pkg::N_DONE : vna_pkg::N_SHIFT;
                          end
      vna_pkg::N_SHIFT:   if (shift_ok) state_nxt = vna_pkg::N_SQ;
      vna_pkg::N_SQ:      if (cnt_r == 5'd3) state_nxt = vna_pkg::N_SQRT;
      vna_pkg::N_SQRT:    if (bit_r[0]) state_nxt = vna_pkg::N_DIVINIT;
      vna_pkg::N_DIVINIT: state_nxt = vna_pkg::N_DIV;
      vna_pkg::N_DIV:     if (cnt_r == 5'd17) state_nxt = vna_pkg::N_DONE;
      vna_pkg::N_DONE:    state_nxt = vna_pkg::N_IDLE;
      default:            state_nxt = vna_pkg::N_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sts_o.busy = (state_r != vna_pkg::N_IDLE);
    sts_o.done = done_r;
    for (int i = 0; i < 3; i++) begin
      res_o[i] = res_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::N_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == vna_pkg::N_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      vna_pkg::N_IDLE: begin
        if (req_i.start) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vec_i[i][vna_pkg::CR_W-1];
            mag_r[i] <= abs_w[i];
            q_r[i]   <= '0;
          end
          frac16_r <= req_i.frac16;
          x_r      <= '0;
          r_r      <= '0;
          bit_r    <= SQRT_TOP;
          cnt_r    <= '0;
        end
      end
      vna_pkg::N_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (|or_w[63:38]) begin
            mag_r[i] <= mag_r[i] >> 8;
          end else if (|or_w[63:30]) begin
            mag_r[i] <= mag_r[i] >> 1;
          end else if (or_w[29:21] == '0) begin
            mag_r[i] <= mag_r[i] << 8;
          end else if (!or_w[29]) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
      end
      vna_pkg::N_SQ: begin
        if (cnt_r != 5'd3) begin
          mul_r <= sq_sel * sq_sel;
        end
        if (cnt_r != 5'd0) begin
          x_r <= x_r + {4'd0, mul_r};
        end
        cnt_r <= (cnt_r == 5'd3) ? 5'd0 : cnt_r + 5'd1;
      end
      vna_pkg::N_SQRT: begin
        if (x_r >= sq_t) begin
          x_r <= x_r - sq_t;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      vna_pkg::N_DIVINIT: begin
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= {3'd0, n_w[i][46:18]};
          num_r[i] <= n_w[i][17:0];
        end
        cnt_r <= '0;
      end
      vna_pkg::N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (tmp_w[i] >= {1'b0, len_w}) begin
            rem_r[i] <= 32'(tmp_w[i] - {1'b0, len_w});
            q_r[i]   <= {q_r[i][vna_pkg::Q_W-2:0], 1'b1};
          end else begin
            rem_r[i] <= tmp_w[i][31:0];
            q_r[i]   <= {q_r[i][vna_pkg::Q_W-2:0], 1'b0};
          end
          num_r[i] <= num_r[i] << 1;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      vna_pkg::N_DONE: begin
        for (int i = 0; i < 3; i++) begin
          res_r[i] <= neg_r[i] ? -$signed(qc_w[i]) : $signed(qc_w[i]);
        end
      end
      default: begin
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == vna_pkg::N_IDLE)
    else $error("done raised while normaliser still busy");

endmodule

/* rtl/vna_back.sv */
// sequencer with vertex stores, edge and cross product unit and accumulator update
module vna_back #(
  parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  vna_pkg::op_t  head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  vna_out_if.source     out_chan
);

  localparam int AW  = $clog2(VERTEX_DEPTH);
  localparam int DW  = vna_pkg::DATA_W;
  localparam int VW  = 3 * vna_pkg::DATA_W;

  vna_pkg::b_state_t state_r, state_nxt;
  vna_pkg::op_t      op_r;

  logic [VW-1:0]     pos_mem [VERTEX_DEPTH];
  logic [VW-1:0]     acc_mem [VERTEX_DEPTH];
  logic [VW-1:0]     pos_rd_r, acc_rd_r;
  logic [VW-1:0]     pos_wd, acc_wd;
  logic [AW-1:0]     pos_wa, acc_wa, rd_a;
  logic              pos_we, acc_we;
  logic [vna_pkg::IDX_W-1:0] corner;

  logic [1:0]        k_r;
  logic [2:0]        mc_r;
  logic [VW-1:0]     p_r [3];
  logic signed [DW:0]   d0_r [3], d1_r [3];
  logic signed [DW:0]   h0_w [3], h1_w [3];
  logic signed [DW-1:0] e0_w [3], e1_w [3];
  logic signed [DW-1:0] e0_r [3], e1_r [3];
  logic              wide_w;
  logic signed [DW-1:0] ma, mb;
  logic signed [2*DW-1:0] mul_r;
  logic signed [vna_pkg::CR_W-1:0] cr_r [3];
  logic signed [vna_pkg::CR_W-1:0] vec_w [3];
  logic signed [vna_pkg::FACE_W-1:0] face_r [3];
  logic signed [vna_pkg::FACE_W-1:0] nres [3];
  logic signed [DW:0]   sum_w [3];
  logic [DW-1:0]        sat_w [3];

  vna_pkg::norm_req_t nreq;
  vna_pkg::norm_sts_t nsts;

  logic              out_load;
  logic              out_valid_r, out_valid_nxt;
  logic signed [vna_pkg::UNIT_W-1:0] ux_r, uy_r, uz_r;
  logic              is_tri;

  assign is_tri = (op_r.kind == vna_pkg::OP_TRI);
  assign pop_o  = (state_r == vna_pkg::B_IDLE) && head_valid_i;

  always_comb begin
    case (k_r)
      2'd0:    corner = op_r.idx_a;
      2'd1:    corner = op_r.idx_b;
      default: corner = op_r.idx_c;
    endcase
  end
  assign rd_a = AW'(corner);

  // vertex store write ports
  always_comb begin
    pos_we = pop_o && (head_i.kind == vna_pkg::OP_WRITE);
    pos_wa = AW'(head_i.idx_a);
    pos_wd = {head_i.pos_x, head_i.pos_y, head_i.pos_z};
    acc_we = pos_we || (state_r == vna_pkg::B_AC && is_tri);
    acc_wa = pos_we ? AW'(head_i.idx_a) : rd_a;
    acc_wd = pos_we ? {head_i.nrm_x, head_i.nrm_y, head_i.nrm_z}
                    : {sat_w[0], sat_w[1], sat_w[2]};
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd_r <= pos_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd_r <= acc_mem[rd_a];
  end

  // edges, halving of wide edges, saturating accumulate
  always_comb begin
    wide_w = 1'b0;
    for (int i = 0; i < 3; i++) begin
      wide_w = wide_w || (d0_r[i][DW] != d0_r[i][DW-1]) || (d1_r[i][DW] != d1_r[i][DW-1]);
    end
    for (int i = 0; i < 3; i++) begin
      h0_w[i] = d0_r[i] + (d0_r[i][DW] ? 33'sd1 : 33'sd0);
      h1_w[i] = d1_r[i] + (d1_r[i][DW] ? 33'sd1 : 33'sd0);
      e0_w[i] = wide_w ? h0_w[i][DW:1] : d0_r[i][DW-1:0];
      e1_w[i] = wide_w ? h1_w[i][DW:1] : d1_r[i][DW-1:0];
      sum_w[i] = 33'($signed(acc_rd_r[VW-1-DW*i -: DW])) + 33'(face_r[i]);
      if (sum_w[i][DW] != sum_w[i][DW-1]) begin
        sat_w[i] = sum_w[i][DW] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        sat_w[i] = sum_w[i][DW-1:0];
      end
    end
  end

  // cross product operand order
  always_comb begin
    case (mc_r)
      3'd0:    begin ma = e0_r[1]; mb = e1_r[2]; end
      3'd1:    begin ma = e0_r[2]; mb = e1_r[1]; end
      3'd2:    begin ma = e0_r[2]; mb = e1_r[0]; end
      3'd3:    begin ma = e0_r[0]; mb = e1_r[2]; end
      3'd4:    begin ma = e0_r[0]; mb = e1_r[1]; end
      3'd5:    begin ma = e0_r[1]; mb = e1_r[0]; end
      default: begin ma = e0_r[0]; mb = e1_r[0]; end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec_w[i] = (state_r == vna_pkg::B_NSTART) ? cr_r[i]
               : vna_pkg::CR_W'($signed(acc_rd_r[VW-1-DW*i -: DW]));
    end
    nreq.start  = (state_r == vna_pkg::B_NSTART) || (state_r == vna_pkg::B_AC && !is_tri);
    nreq.frac16 = (state_r == vna_pkg::B_NSTART);
  end

  vna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (nreq),
    .vec_i (vec_w),
    .sts_o (nsts),
    .res_o (nres)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vna_pkg::B_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            vna_pkg::OP_TRI:       state_nxt = vna_pkg::B_PR;
            vna_pkg::OP_READ:      state_nxt = vna_pkg::B_AR;
            vna_pkg::OP_READ_ZERO: state_nxt = vna_pkg::B_OUT;
            default:               state_nxt = vna_pkg::B_IDLE;
          endcase
        end
      end
      vna_pkg::B_PR:     state_nxt = vna_pkg::B_PC;
      vna_pkg::B_PC:     state_nxt = (k_r == 2'd2) ? vna_pkg::B_EDGE : vna_pkg::B_PR;
      vna_pkg::B_EDGE:   state_nxt = vna_pkg::B_HALF;
      vna_pkg::B_HALF:   state_nxt = vna_pkg::B_MUL;
      vna_pkg::B_MUL:    if (mc_r == 3'd6) state_nxt = vna_pkg::B_NSTART;
      vna_pkg::B_NSTART: state_nxt = vna_pkg::B_NWAIT;
      vna_pkg::B_NWAIT:  if (nsts.done) state_nxt = is_tri ? vna_pkg::B_AR : vna_pkg::B_OUT;
      vna_pkg::B_AR:     state_nxt = vna_pkg::B_AC;
      vna_pkg::B_AC: begin
        if (!is_tri) begin
          state_nxt = vna_pkg::B_NWAIT;
        end else if (k_r == 2'd2) begin
          state_nxt = vna_pkg::B_IDLE;
        end else begin
          state_nxt = vna_pkg::B_AR;
        end
      end
      vna_pkg::B_OUT:    if (out_load) state_nxt = vna_pkg::B_IDLE;
      default:           state_nxt = vna_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_load      = (state_r == vna_pkg::B_OUT) && (!out_valid_r || out_chan.ready);
    out_valid_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
    out_chan.valid   = out_valid_r;
    out_chan.unit_nx = ux_r;
    out_chan.unit_ny = uy_r;
    out_chan.unit_nz = uz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vna_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
      mc_r        <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      case (state_r)
        vna_pkg::B_IDLE:  k_r  <= 2'd0;
        vna_pkg::B_PC:    k_r  <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        vna_pkg::B_AC:    k_r  <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        vna_pkg::B_NWAIT: k_r  <= 2'd0;
        vna_pkg::B_MUL:   mc_r <= (mc_r == 3'd6) ? 3'd0 : mc_r + 3'd1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      op_r <= head_i;
    end
    case (state_r)
      vna_pkg::B_PC: p_r[k_r] <= pos_rd_r;
      vna_pkg::B_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          d0_r[i] <= 33'($signed(p_r[1][VW-1-DW*i -: DW])) - 33'($signed(p_r[0][VW-1-DW*i -: DW]));
          d1_r[i] <= 33'($signed(p_r[2][VW-1-DW*i -: DW])) - 33'($signed(p_r[0][VW-1-DW*i -: DW]));
        end
      end
      vna_pkg::B_HALF: begin
        for (int i = 0; i < 3; i++) begin
          e0_r[i] <= e0_w[i];
          e1_r[i] <= e1_w[i];
        end
      end
      vna_pkg::B_MUL: begin
        if (mc_r != 3'd6) begin
          mul_r <= ma * mb;
        end
        case (mc_r)
          3'd1:    cr_r[0] <= vna_pkg::CR_W'(mul_r);
          3'd2:    cr_r[0] <= cr_r[0] - vna_pkg::CR_W'(mul_r);
          3'd3:    cr_r[1] <= vna_pkg::CR_W'(mul_r);
          3'd4:    cr_r[1] <= cr_r[1] - vna_pkg::CR_W'(mul_r);
          3'd5:    cr_r[2] <= vna_pkg::CR_W'(mul_r);
          3'd6:    cr_r[2] <= cr_r[2] - vna_pkg::CR_W'(mul_r);
          default: begin
          end
        endcase
      end
      vna_pkg::B_NWAIT: begin
        if (nsts.done) begin
          for (int i = 0; i < 3; i++) begin
            face_r[i] <= nres[i];
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      if (op_r.kind == vna_pkg::OP_READ_ZERO) begin
        ux_r <= '0;
        uy_r <= '0;
        uz_r <= '0;
      end else begin
        ux_r <= nres[0][vna_pkg::UNIT_W-1:0];
        uy_r <= nres[1][vna_pkg::UNIT_W-1:0];
        uz_r <= nres[2][vna_pkg::UNIT_W-1:0];
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    nreq.start |-> !nsts.busy)
    else $error("normaliser started while busy");
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_chan.ready))
    else $error("result register overwritten before transaction");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> state_r != vna_pkg::B_IDLE || $past(head_i.kind) == vna_pkg::OP_WRITE)
    else $error("command taken without leaving idle");

endmodule

/* rtl/vertex_normal_accumulator.sv */
// vertex normal accumulator top level: command queue, sequencer and read-out register
//
//  port      | dir | handshake     | payload
//  in_chan   | in  | valid/ready   | command, index_a/b/c, pos_x/y/z_in, start_nx/ny/nz
//  out_chan  | out | valid/ready   | unit_nx, unit_ny, unit_nz (Q1.14)
//
//  the normaliser runs a 32-step square root and an 18-step division
//  the number of range shift steps depends on operand magnitude
//  synchronous active-low reset clears control only; vertex stores are not cleared
//  a two-entry queue takes commands while the sequencer or output stalls, until full
module vertex_normal_accumulator #(
  parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vna_in_if.sink     in_chan,
  vna_out_if.source  out_chan
);

  vna_pkg::op_t head;
  logic         head_valid;
  logic         pop;

  vna_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  vna_back #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_chan     (out_chan)
  );

endmodule
